FILE: sv/i2cmrt_pkg.sv
// Package for the I2C master register transfer block.
// Holds the sequencer state type, field widths and reset constants.
// No dependencies.
package i2cmrt_pkg;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [7:0] POLL_LIMIT_RESET = 8'd200;
  localparam logic       READ_BIT         = 1'b1;

  typedef enum logic [14:0] {
    ST_IDLE      = 15'b000000000000001,
    ST_START1    = 15'b000000000000010,
    ST_ADDRW     = 15'b000000000000100,
    ST_ACK_ADDRW = 15'b000000000001000,
    ST_REG       = 15'b000000000010000,
    ST_ACK_REG   = 15'b000000000100000,
    ST_START2    = 15'b000000001000000,
    ST_ADDRR     = 15'b000000010000000,
    ST_ACK_ADDRR = 15'b000000100000000,
    ST_RX        = 15'b000001000000000,
    ST_MACK      = 15'b000010000000000,
    ST_TX        = 15'b000100000000000,
    ST_ACK_TX    = 15'b001000000000000,
    ST_STOP      = 15'b010000000000000,
    ST_STOP_ERR  = 15'b100000000000000
  } seq_state_t;

  typedef struct packed {
    logic       error;
    logic       done_res;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       data_req;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } out_word_t;

endpackage

FILE: sv/i2c_master_register_transfer.sv
// Top level of the I2C master register transfer block.
// Quarter-bit sequencer with a result register; depends on i2cmrt_pkg.
//
// Each accepted input transaction is one quarter-bit tick of the bus and yields exactly one
// registered result transaction, carrying the SCL and SDA drive levels and status.
// A tick is taken in every clock while the result register is empty or being read, so the
// block sustains one tick per cycle; the only limit is the single result register, which
// holds its contents while out_tready is low. A read or write of N bytes takes 4 ticks per
// bus element plus any acknowledge polling; an acknowledge that never comes is given up
// after one more polled tick than the limit written through cfg_wr_data.
module i2c_master_register_transfer
  import i2cmrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_req, mode, dev_addr[6:0], reg_addr[7:0], byte_count[7:0], wr_data[7:0], sda_in
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // scl_out, sda_out, busy_res, data_req, rd_data[7:0], rd_valid, done_res, error
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic       start_req, mode, sda_in;
  logic [6:0] dev_addr;
  logic [7:0] reg_addr, byte_count, wr_data;

  assign start_req  = in_tdata[0];
  assign mode       = in_tdata[1];
  assign dev_addr   = in_tdata[8:2];
  assign reg_addr   = in_tdata[16:9];
  assign byte_count = in_tdata[24:17];
  assign wr_data    = in_tdata[32:25];
  assign sda_in     = in_tdata[33];

  logic [7:0] poll_limit_r;

  seq_state_t state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] bit_idx_r, bit_idx_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] poll_cnt_r, poll_cnt_nxt;
  logic       is_write_r, is_write_nxt;
  logic [6:0] dev_r, dev_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;

  out_word_t  out_r, out_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r;
  logic       accept;

  logic       is_send, is_ack;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r};
  assign out_tlast  = last_r;

  assign is_send = state_r inside {ST_ADDRW, ST_REG, ST_ADDRR, ST_TX};
  assign is_ack  = state_r inside {ST_ACK_ADDRW, ST_ACK_REG, ST_ACK_ADDRR, ST_ACK_TX};

  always_comb begin
    logic [7:0] rx_byte;
    logic       go_write;
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    bit_idx_nxt    = bit_idx_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    poll_cnt_nxt   = poll_cnt_r;
    is_write_nxt   = is_write_r;
    dev_nxt        = dev_r;
    reg_nxt        = reg_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    out_nxt        = '0;
    last_nxt       = 1'b0;
    rx_byte        = {shift_r[6:0], sda_in};
    go_write       = 1'b0;

    if (state_r == ST_IDLE) begin
      phase_nxt   = 2'd0;
      bit_idx_nxt = 3'd0;
      scl_nxt     = 1'b1;
      sda_nxt     = 1'b1;
      if (start_req) begin
        is_write_nxt     = mode;
        dev_nxt          = dev_addr;
        reg_nxt          = reg_addr;
        bytes_left_nxt   = byte_count;
        poll_cnt_nxt     = 8'd0;
        state_nxt        = ST_START1;
        out_nxt.busy_res = 1'b1;
      end
    end else begin
      out_nxt.busy_res = 1'b1;
      case (phase_r)
        2'd0: begin
          scl_nxt   = 1'b0;
          phase_nxt = 2'd1;
        end
        2'd1: begin
          if (is_send) begin
            sda_nxt = shift_r[3'd7 - bit_idx_r];
          end else if (state_r == ST_MACK) begin
            sda_nxt = (bytes_left_r == 8'd0);
          end else if (state_r inside {ST_STOP, ST_STOP_ERR}) begin
            sda_nxt = 1'b0;
          end else begin
            sda_nxt = 1'b1;
          end
          phase_nxt = 2'd2;
        end
        2'd2: begin
          scl_nxt = 1'b1;
          if (is_ack) begin
            poll_cnt_nxt = 8'd0;
          end
          phase_nxt = 2'd3;
        end
        default: begin
          phase_nxt   = 2'd0;
          bit_idx_nxt = 3'd0;
          case (state_r)
            ST_START1: begin
              sda_nxt   = 1'b0;
              state_nxt = ST_ADDRW;
              shift_nxt = {dev_r, 1'b0};
            end
            ST_START2: begin
              sda_nxt   = 1'b0;
              state_nxt = ST_ADDRR;
              shift_nxt = {dev_r, READ_BIT};
            end
            ST_ADDRW, ST_REG, ST_ADDRR, ST_TX: begin
              if (bit_idx_r == 3'd7) begin
                case (state_r)
                  ST_ADDRW: state_nxt = ST_ACK_ADDRW;
                  ST_REG:   state_nxt = ST_ACK_REG;
                  ST_ADDRR: state_nxt = ST_ACK_ADDRR;
                  default:  state_nxt = ST_ACK_TX;
                endcase
              end else begin
                bit_idx_nxt = bit_idx_r + 3'd1;
              end
            end
            ST_ACK_ADDRW, ST_ACK_REG, ST_ACK_ADDRR, ST_ACK_TX: begin
              if (!sda_in) begin
                case (state_r)
                  ST_ACK_ADDRW: begin
                    state_nxt = ST_REG;
                    shift_nxt = reg_r;
                  end
                  ST_ACK_REG: begin
                    if (is_write_r) begin
                      go_write = 1'b1;
                    end else begin
                      state_nxt = ST_START2;
                    end
                  end
                  ST_ACK_ADDRR: begin
                    state_nxt = (bytes_left_r != 8'd0) ? ST_RX : ST_STOP;
                  end
                  default: go_write = 1'b1;
                endcase
              end else if (poll_cnt_r >= poll_limit_r) begin
                state_nxt = ST_STOP_ERR;
              end else begin
                poll_cnt_nxt = poll_cnt_r + 8'd1;
                phase_nxt    = phase_r;
                bit_idx_nxt  = bit_idx_r;
              end
              if (go_write) begin
                if (bytes_left_r != 8'd0) begin
                  state_nxt        = ST_TX;
                  shift_nxt        = wr_data;
                  bytes_left_nxt   = bytes_left_r - 8'd1;
                  out_nxt.data_req = 1'b1;
                end else begin
                  state_nxt = ST_STOP;
                end
              end
            end
            ST_RX: begin
              shift_nxt = rx_byte;
              if (bit_idx_r == 3'd7) begin
                out_nxt.rd_data  = rx_byte;
                out_nxt.rd_valid = 1'b1;
                last_nxt         = (bytes_left_r == 8'd1);
                if (bytes_left_r != 8'd0) begin
                  bytes_left_nxt = bytes_left_r - 8'd1;
                end
                state_nxt = ST_MACK;
              end else begin
                bit_idx_nxt = bit_idx_r + 3'd1;
              end
            end
            ST_MACK: begin
              state_nxt = (bytes_left_r == 8'd0) ? ST_STOP : ST_RX;
            end
            ST_STOP, ST_STOP_ERR: begin
              sda_nxt          = 1'b1;
              out_nxt.done_res = 1'b1;
              out_nxt.error    = (state_r == ST_STOP_ERR);
              state_nxt        = ST_IDLE;
            end
            default: begin
              state_nxt        = ST_IDLE;
              scl_nxt          = 1'b1;
              sda_nxt          = 1'b1;
              out_nxt.busy_res = 1'b0;
            end
          endcase
        end
      endcase
    end

    out_nxt.scl_out = scl_nxt;
    out_nxt.sda_out = sda_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= POLL_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      poll_limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= 2'd0;
      bit_idx_r    <= 3'd0;
      shift_r      <= 8'd0;
      bytes_left_r <= 8'd0;
      poll_cnt_r   <= 8'd0;
      is_write_r   <= 1'b0;
      dev_r        <= 7'd0;
      reg_r        <= 8'd0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        state_r      <= state_nxt;
        phase_r      <= phase_nxt;
        bit_idx_r    <= bit_idx_nxt;
        shift_r      <= shift_nxt;
        bytes_left_r <= bytes_left_nxt;
        poll_cnt_r   <= poll_cnt_nxt;
        is_write_r   <= is_write_nxt;
        dev_r        <= dev_nxt;
        reg_r        <= reg_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r  <= out_nxt;
      last_r <= last_nxt;
    end
  end

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the I2C master register transfer block.
// Feeds quarter-bit ticks with a reactive target on SDA and checks every result tick.
// Depends on i2cmrt_pkg and i2c_master_register_transfer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cmrt_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int QUIET_LIMIT  = 1000;
  localparam int TOTAL_TICKS  = 1900;
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam logic [7:0] POLL_LIMIT_MIN = 8'd1;
  localparam logic [7:0] POLL_LIMIT_MAX = 8'd255;

  typedef struct {
    logic       start_req;
    logic       mode;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wr_data;
    logic       sda_in;
  } bus_tick_in_t;

  typedef struct {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       data_req;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_last;
    logic       done;
    logic       error;
  } line_state_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [7:0]            cfg_wr_data = '0;
  logic                  in_tvalid   = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tready  = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  // Predicted sequencer state, advanced once per accepted tick.
  seq_state_t sq_state = ST_IDLE;
  logic [1:0] sq_phase = '0;
  logic [3:0] sq_bit   = '0;
  logic [7:0] sq_shift = '0;
  logic [7:0] sq_left  = '0;
  logic [7:0] sq_poll  = '0;
  logic       sq_write = 1'b0;
  logic [6:0] sq_dev   = '0;
  logic [7:0] sq_reg   = '0;
  logic       sq_scl   = 1'b1;
  logic       sq_sda   = 1'b1;
  logic [7:0] poll_limit = POLL_LIMIT_RESET;

  line_state_t line_states_due[$];

  int burst_left   = 0;
  int ticks_sent   = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;
  int stall_mode   = 0;
  int mode_left    = 0;
  int stall_count  = 0;

  i2c_master_register_transfer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic bit is_ack_state(seq_state_t st);
    return st inside {ST_ACK_ADDRW, ST_ACK_REG, ST_ACK_ADDRR, ST_ACK_TX};
  endfunction

  function automatic bit is_send_state(seq_state_t st);
    return st inside {ST_ADDRW, ST_REG, ST_ADDRR, ST_TX};
  endfunction

  function automatic void enter_state(seq_state_t st);
    sq_state = st;
    sq_phase = '0;
    sq_bit   = '0;
  endfunction

  function automatic void enter_send(seq_state_t st, logic [7:0] value);
    enter_state(st);
    sq_shift = value;
  endfunction

  // Loads the next write byte, or heads for STOP when none are left.
  function automatic logic load_next_write(logic [7:0] wr_data);
    if (sq_left != 0) begin
      enter_send(ST_TX, wr_data);
      sq_left = sq_left - 8'd1;
      return 1'b1;
    end
    enter_state(ST_STOP);
    return 1'b0;
  endfunction

  function automatic void step_sequencer(input bus_tick_in_t t, output line_state_t r);
    seq_state_t st;
    logic       v;
    st = sq_state;
    r = '{default: '0};
    if (st == ST_IDLE) begin
      sq_scl = 1'b1;
      sq_sda = 1'b1;
      enter_state(ST_IDLE);
      if (t.start_req) begin
        sq_write = t.mode;
        sq_dev   = t.dev_addr;
        sq_reg   = t.reg_addr;
        sq_left  = t.byte_count;
        sq_poll  = '0;
        enter_state(ST_START1);
        r.busy = 1'b1;
      end
    end else begin
      r.busy = 1'b1;
      case (sq_phase)
        2'd0: begin
          sq_scl   = 1'b0;
          sq_phase = 2'd1;
        end
        2'd1: begin
          v = 1'b1;
          if (is_send_state(st))
            v = sq_shift[3'd7 - sq_bit[2:0]];
          else if (st == ST_MACK)
            v = (sq_left == 0);
          else if (st inside {ST_STOP, ST_STOP_ERR})
            v = 1'b0;
          sq_sda   = v;
          sq_phase = 2'd2;
        end
        2'd2: begin
          sq_scl = 1'b1;
          if (is_ack_state(st))
            sq_poll = '0;
          sq_phase = 2'd3;
        end
        default: begin
          if (st == ST_START1) begin
            sq_sda = 1'b0;
            enter_send(ST_ADDRW, {sq_dev, 1'b0});
          end else if (st == ST_START2) begin
            sq_sda = 1'b0;
            enter_send(ST_ADDRR, {sq_dev, READ_BIT});
          end else if (is_send_state(st)) begin
            if (sq_bit >= 4'd7) begin
              case (st)
                ST_ADDRW: enter_state(ST_ACK_ADDRW);
                ST_REG:   enter_state(ST_ACK_REG);
                ST_ADDRR: enter_state(ST_ACK_ADDRR);
                default:  enter_state(ST_ACK_TX);
              endcase
            end else begin
              sq_bit   = sq_bit + 4'd1;
              sq_phase = 2'd0;
            end
          end else if (is_ack_state(st)) begin
            if (!t.sda_in) begin
              case (st)
                ST_ACK_ADDRW: enter_send(ST_REG, sq_reg);
                ST_ACK_REG: begin
                  if (sq_write)
                    r.data_req = load_next_write(t.wr_data);
                  else
                    enter_state(ST_START2);
                end
                ST_ACK_ADDRR: enter_state(sq_left != 0 ? ST_RX : ST_STOP);
                default: r.data_req = load_next_write(t.wr_data);
              endcase
            end else if (sq_poll >= poll_limit) begin
              enter_state(ST_STOP_ERR);
            end else begin
              sq_poll = sq_poll + 8'd1;
            end
          end else if (st == ST_RX) begin
            sq_shift = {sq_shift[6:0], t.sda_in};
            if (sq_bit >= 4'd7) begin
              r.rd_data  = sq_shift;
              r.rd_valid = 1'b1;
              r.rd_last  = (sq_left == 8'd1);
              if (sq_left != 0)
                sq_left = sq_left - 8'd1;
              enter_state(ST_MACK);
            end else begin
              sq_bit   = sq_bit + 4'd1;
              sq_phase = 2'd0;
            end
          end else if (st == ST_MACK) begin
            enter_state(sq_left == 0 ? ST_STOP : ST_RX);
          end else begin
            sq_sda  = 1'b1;
            r.done  = 1'b1;
            r.error = (st == ST_STOP_ERR);
            enter_state(ST_IDLE);
          end
        end
      endcase
    end
    r.scl = sq_scl;
    r.sda = sq_sda;
  endfunction

  function automatic bus_tick_in_t random_tick();
    bus_tick_in_t t;
    t.start_req  = 1'b0;
    t.mode       = 1'($urandom_range(0, 1));
    t.dev_addr   = 7'($urandom_range(0, 127));
    t.reg_addr   = 8'($urandom_range(0, 255));
    t.byte_count = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       t.wr_data = 8'h00;
      1:       t.wr_data = 8'hFF;
      default: t.wr_data = 8'($urandom_range(0, 255));
    endcase
    t.sda_in = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_field(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch(what, int'(got), int'(want));
  endtask

  task automatic send_tick(bus_tick_in_t t);
    line_state_t r;
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      repeat (gap) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, t.sda_in, t.wr_data, t.byte_count, t.reg_addr, t.dev_addr,
                  t.mode, t.start_req};
    do @(posedge clk); while (!in_tready);
    step_sequencer(t, r);
    line_states_due.push_back(r);
    ticks_sent++;
  endtask

  task automatic send_idle_ticks(int n);
    repeat (n) send_tick(random_tick());
  endtask

  task automatic set_poll_limit(logic [7:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (line_states_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    poll_limit = value;
  endtask

  // One register transfer from request to the done tick. The target refuses the
  // acknowledge numbered nack_at for good and otherwise holds SDA high for hi_pct
  // percent of the polled samples.
  task automatic run_transfer(logic mode, logic [6:0] dev_addr, logic [7:0] reg_addr,
                              logic [7:0] count, int nack_at, int hi_pct, int req_pct);
    bus_tick_in_t t;
    int acks_seen;
    bit polling;
    acks_seen = 0;
    polling   = 1'b0;
    t = random_tick();
    t.start_req  = 1'b1;
    t.mode       = mode;
    t.dev_addr   = dev_addr;
    t.reg_addr   = reg_addr;
    t.byte_count = count;
    send_tick(t);
    while (sq_state != ST_IDLE) begin
      t = random_tick();
      t.start_req = ($urandom_range(0, 99) < req_pct);
      if (is_ack_state(sq_state) && sq_phase == 2'd3) begin
        if (!polling) begin
          acks_seen++;
          polling = 1'b1;
        end
        t.sda_in = (acks_seen == nack_at) ? 1'b1 : ($urandom_range(0, 99) < hi_pct);
      end else begin
        polling = 1'b0;
      end
      send_tick(t);
    end
    send_idle_ticks($urandom_range(0, 2));
  endtask

  task automatic test_idle_lines();
    send_idle_ticks(6);
  endtask

  task automatic test_register_read();
    run_transfer(MODE_READ, 7'h7F, 8'hFF, 8'd1, 0, 0, 0);
    run_transfer(MODE_READ, 7'h00, 8'h00, 8'd3, 0, 20, 0);
  endtask

  task automatic test_register_write();
    run_transfer(MODE_WRITE, 7'h2A, 8'h55, 8'd2, 0, 0, 0);
    run_transfer(MODE_WRITE, 7'h55, 8'hAA, 8'd3, 0, 20, 0);
  endtask

  task automatic test_zero_byte_count();
    run_transfer(MODE_READ, 7'h11, 8'h3C, 8'd0, 0, 10, 0);
    run_transfer(MODE_WRITE, 7'h6E, 8'hC3, 8'd0, 0, 10, 0);
  endtask

  task automatic test_requests_while_busy();
    run_transfer(MODE_READ, 7'h40, 8'h81, 8'd1, 0, 0, 100);
    run_transfer(MODE_WRITE, 7'h01, 8'h7E, 8'd1, 0, 0, 100);
  endtask

  task automatic test_ack_timeout();
    set_poll_limit(POLL_LIMIT_MIN);
    run_transfer(MODE_WRITE, 7'h33, 8'h10, 8'd4, 1, 0, 0);
    run_transfer(MODE_READ, 7'h4C, 8'hE0, 8'd255, 3, 0, 0);
    set_poll_limit(POLL_LIMIT_MAX);
    run_transfer(MODE_READ, 7'h62, 8'h9D, 8'd2, 2, 0, 0);
  endtask

  task automatic test_random_transfers();
    int transfers;
    logic [7:0] count;
    int nack_at;
    transfers = 0;
    do begin
      if (transfers % 3 == 0) begin
        case ($urandom_range(0, 3))
          0:       set_poll_limit(POLL_LIMIT_MIN);
          1:       set_poll_limit(POLL_LIMIT_MAX);
          default: set_poll_limit(8'($urandom_range(2, 254)));
        endcase
      end
      if ($urandom_range(0, 4) == 0) begin
        count   = 8'($urandom_range(0, 255));
        nack_at = int'($urandom_range(1, 3));
      end else begin
        count   = 8'($urandom_range(0, 3));
        nack_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 6)) : 0;
      end
      run_transfer(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                   8'($urandom_range(0, 255)), count, nack_at,
                   int'($urandom_range(0, 30)), int'($urandom_range(0, 50)));
      transfers++;
    end while (ticks_sent < TOTAL_TICKS);
  endtask

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_count <= stall_count + 1;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (stall_count % 5) != 0;
      default: out_tready <= (stall_count % 16) >= 10;
    endcase
  end

  always @(posedge clk) begin
    line_state_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (line_states_due.size() == 0) begin
        report_mismatch("result with no expected transaction", int'(out_tdata), 0);
      end else begin
        want = line_states_due.pop_front();
        compare_field("scl_out", 8'(out_tdata[0]), 8'(want.scl));
        compare_field("sda_out", 8'(out_tdata[1]), 8'(want.sda));
        compare_field("busy_res", 8'(out_tdata[2]), 8'(want.busy));
        compare_field("data_req", 8'(out_tdata[3]), 8'(want.data_req));
        compare_field("rd_data", out_tdata[11:4], want.rd_data);
        compare_field("rd_valid", 8'(out_tdata[12]), 8'(want.rd_valid));
        compare_field("done_res", 8'(out_tdata[13]), 8'(want.done));
        compare_field("error", 8'(out_tdata[14]), 8'(want.error));
        compare_field("rd_last", 8'(out_tlast), 8'(want.rd_last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_lines();
    test_register_read();
    test_register_write();
    test_zero_byte_count();
    test_requests_while_busy();
    test_ack_timeout();
    test_random_transfers();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (line_states_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (line_states_due.size() != 0)
      report_mismatch("expected transactions left over", line_states_due.size(), 0);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
